/* design/mkh_pkg.sv */
// shared types and constants for the key hash unit
`timescale 1ns / 1ps

package mkh_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned HASH_W = 32;
  localparam logic [HASH_W-1:0] MIX_MUL = 32'h5bd1e995;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'h7870AAFF;
  localparam int unsigned MIX_SHIFT = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_K1,
    OP_K2,
    OP_H,
    OP_TAIL,
    OP_AVAL
  } mul_op_t;

  typedef struct packed {
    logic absorb;
    mul_op_t op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty_key;
    logic word_full;
    logic out_free;
  } stat_t;

endpackage

/* design/murmur2_key_hash_unit.sv */
// top level of the streaming 32-bit key hash unit
`timescale 1ns / 1ps

// Takes a key one byte per request and returns its 32-bit MurmurHash2 after
// the byte marked last. A first request with zero length and the last mark
// returns 0 through the load step alone, and no key is started. A byte that
// completes a four-byte word starts the word mix, which runs three multiplies
// through the one shared 32x32 multiplier while the input stalls.
// After the last byte the unit folds in leftover bytes when there are any,
// runs one avalanche multiply and loads the result register. The result
// register then holds the hash while the next key streams in. The load waits
// while an earlier hash is still held by out_stall, and the input stays
// stalled for that time. The seed register may be written at any time and
// applies from the next key on.
module murmur2_key_hash_unit (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mkh_pkg::HASH_W-1:0] hash_seed,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] key_byte,
  input  logic [mkh_pkg::LENGTH_BITS-1:0] key_length,
  input  logic last_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [mkh_pkg::HASH_W-1:0] hash_value
);
  import mkh_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic key_active;

  assign cfg_ready = 1'b1;

  mkh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_byte(last_byte),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mkh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .hash_seed (hash_seed),
    .key_byte  (key_byte),
    .key_length(key_length),
    .last_byte (last_byte),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .hash_value(hash_value),
    .key_active(key_active)
  );

`ifndef ASSERT_OFF
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  a_empty_key_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !key_active && key_length == '0 && last_byte)
    |=> !key_active && in_stall)
    else $error("empty key started a key or skipped the result");

  a_mul_only_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> in_stall && !cmd.absorb)
    else $error("multiplier step while taking a request");
`endif

endmodule

/* design/mkh_ctrl.sv */
// sequencer for byte absorb, word mixing and finish steps
`timescale 1ns / 1ps

module mkh_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic last_byte,
  input  mkh_pkg::stat_t stat,
  output mkh_pkg::cmd_t cmd,
  output logic in_stall
);
  import mkh_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MIX1 = 7'b0000010,
    ST_MIX2 = 7'b0000100,
    ST_MIX3 = 7'b0001000,
    ST_FIN1 = 7'b0010000,
    ST_FIN2 = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic last_q, last_q_next;
  logic accept;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    last_q_next = last_q;
    cmd.absorb = 1'b0;
    cmd.op = OP_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.absorb = 1'b1;
          last_q_next = last_byte;
          if (stat.empty_key) begin
            state_next = ST_EMIT;
          end else if (stat.word_full) begin
            state_next = ST_MIX1;
          end else if (last_byte) begin
            state_next = ST_FIN1;
          end
        end
      end
      ST_MIX1: begin
        cmd.op = OP_K1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.op = OP_K2;
        state_next = ST_MIX3;
      end
      ST_MIX3: begin
        cmd.op = OP_H;
        state_next = last_q ? ST_FIN2 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.op = OP_TAIL;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op = OP_AVAL;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      last_q <= last_q_next;
    end
  end

endmodule

/* design/mkh_datapath.sv */
// hash registers, shared multiplier and result register
`timescale 1ns / 1ps

module mkh_datapath (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [mkh_pkg::HASH_W-1:0] hash_seed,
  input  logic [7:0] key_byte,
  input  logic [mkh_pkg::LENGTH_BITS-1:0] key_length,
  input  logic last_byte,
  input  logic out_stall,
  input  mkh_pkg::cmd_t cmd,
  output mkh_pkg::stat_t stat,
  output logic out_valid,
  output logic [mkh_pkg::HASH_W-1:0] hash_value,
  output logic key_active
);
  import mkh_pkg::*;

  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] h, h_next;
  logic [HASH_W-1:0] k, k_next;
  logic [23:0] pend, pend_next;
  logic [1:0] phase, phase_next;
  logic active_next;
  logic [HASH_W-1:0] h_base;
  logic [23:0] pend_base;
  logic [1:0] phase_base;
  logic [HASH_W-1:0] operand;
  logic [HASH_W-1:0] product;
  logic empty_key;

  assign empty_key = !key_active && (key_length == '0) && last_byte;

  always_comb begin
    if (key_active) begin
      h_base = h;
      pend_base = pend;
      phase_base = phase;
    end else begin
      h_base = seed ^ HASH_W'(key_length);
      pend_base = '0;
      phase_base = '0;
    end
  end

  assign stat.empty_key = empty_key;
  assign stat.word_full = (phase_base == 2'd3);
  assign stat.out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.op)
      OP_K1:   operand = k;
      OP_K2:   operand = k ^ (k >> MIX_SHIFT);
      OP_H:    operand = h;
      OP_TAIL: operand = h ^ HASH_W'(pend);
      OP_AVAL: operand = h ^ (h >> FIN_SHIFT_A);
      default: operand = h;
    endcase
  end

  assign product = operand * MIX_MUL;

  always_comb begin
    h_next = h;
    k_next = k;
    pend_next = pend;
    phase_next = phase;
    active_next = key_active;
    if (cmd.absorb) begin
      if (empty_key) begin
        h_next = '0;
      end else begin
        h_next = h_base;
        active_next = 1'b1;
        if (phase_base == 2'd3) begin
          k_next = {key_byte, pend_base};
          pend_next = '0;
          phase_next = '0;
        end else begin
          pend_next = pend_base | (24'(key_byte) << {phase_base, 3'b000});
          phase_next = phase_base + 2'd1;
        end
      end
    end
    unique case (cmd.op)
      OP_K1, OP_K2: k_next = product;
      OP_H:         h_next = product ^ k;
      OP_TAIL, OP_AVAL: h_next = product;
      default: ;
    endcase
    if (cmd.load_out) begin
      active_next = 1'b0;
      pend_next = '0;
      phase_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    h <= h_next;
    k <= k_next;
    pend <= pend_next;
    if (cmd.load_out) begin
      hash_value <= h ^ (h >> FIN_SHIFT_B);
    end
    if (rst) begin
      seed <= SEED_RESET;
      phase <= '0;
      key_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed <= hash_seed;
      end
      phase <= phase_next;
      key_active <= active_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sim/tb_murmur2_key_hash_unit.sv */
// testbench for the key hash unit: byte-serial keys checked against a MurmurHash2 predictor
`timescale 1ns / 1ps

module tb_murmur2_key_hash_unit;
  import mkh_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic [LENGTH_BITS-1:0] len;
    logic last;
  } key_req_t;

  class hash_tracker;
    logic [HASH_W-1:0] seed;
    logic [HASH_W-1:0] running;
    logic [23:0] pending;
    logic [1:0] phase;
    logic active;
    logic [HASH_W-1:0] expected_hashes[$];
    int mismatches;
    int hashes_seen;

    function new();
      seed = SEED_RESET;
      running = '0;
      pending = '0;
      phase = '0;
      active = 1'b0;
      mismatches = 0;
      hashes_seen = 0;
    endfunction

    function void take_byte(logic [7:0] data, logic [LENGTH_BITS-1:0] len, logic last);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] k;
      if (!active) begin
        if (len == '0 && last) begin
          expected_hashes.push_back('0);
          return;
        end
        running = seed ^ HASH_W'(len);
        pending = '0;
        phase = '0;
        active = 1'b1;
      end
      if (phase == 2'd3) begin
        k = {data, pending};
        k = k * MIX_MUL;
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MUL;
        h = running * MIX_MUL;
        running = h ^ k;
        pending = '0;
        phase = '0;
      end else begin
        pending = pending | (24'(data) << (8 * phase));
        phase = phase + 2'd1;
      end
      if (!last) return;
      h = running;
      if (phase != 2'd0) begin
        h = h ^ HASH_W'(pending);
        h = h * MIX_MUL;
      end
      h = h ^ (h >> FIN_SHIFT_A);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SHIFT_B);
      expected_hashes.push_back(h);
      running = '0;
      pending = '0;
      phase = '0;
      active = 1'b0;
    endfunction

    function void check_hash(logic [HASH_W-1:0] got);
      logic [HASH_W-1:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected none, actual %h", got);
        mismatches++;
        return;
      end
      want = expected_hashes.pop_front();
      hashes_seen++;
      if (got !== want) begin
        $error("hash_value: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [HASH_W-1:0] seed_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] key_byte = '0;
  logic [LENGTH_BITS-1:0] key_length = '0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HASH_W-1:0] hash_value;

  hash_tracker tracker = new();
  key_req_t req_q[$];
  bit sender_gaps = 1'b1;
  bit long_hold_req = 1'b0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int seeds_written = 0;

  murmur2_key_hash_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .hash_seed(seed_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_byte(key_byte),
    .key_length(key_length),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hash_value(hash_value)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_hash(hash_value);
  end

  initial begin : receiver
    int hold_left;
    int pat_left;
    int r;
    logic [31:0] stall_pat;
    hold_left = 0;
    pat_left = 0;
    stall_pat = '0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          r = $urandom_range(0, 3);
          stall_pat = (r == 0) ? 32'h0 : (r == 1) ? ($urandom & $urandom) : $urandom;
          pat_left = 32;
        end
        pat_left--;
        out_stall <= stall_pat[pat_left];
      end
    end
  end

  function automatic void queue_key(int n, logic [LENGTH_BITS-1:0] len_field, int fill,
                                    bit closes, bit junk_len = 1'b0);
    key_req_t req;
    for (int i = 0; i < n; i++) begin
      req.data = (fill < 0) ? 8'($urandom) : 8'(fill);
      req.len = (i != 0 && junk_len) ? LENGTH_BITS'($urandom) : len_field;
      req.last = closes && (i == n - 1);
      req_q.push_back(req);
    end
  endfunction

  function automatic void queue_random_keys(int n_items);
    int start;
    int n;
    int r;
    logic [LENGTH_BITS-1:0] len_field;
    start = req_q.size();
    while (req_q.size() - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        n = 1;
        len_field = '0;
      end else begin
        if (r < 70) n = $urandom_range(1, 8);
        else if (r < 92) n = $urandom_range(9, 24);
        else n = $urandom_range(25, 64);
        r = $urandom_range(0, 99);
        if (r < 85) len_field = LENGTH_BITS'(n);
        else if (r < 94) len_field = LENGTH_BITS'($urandom);
        else len_field = '0;
      end
      queue_key(n, len_field, -1, 1'b1, $urandom_range(0, 3) == 0);
    end
  endfunction

  task automatic send_all();
    int burst;
    int gap;
    key_req_t cur;
    while (req_q.size() != 0) begin
      burst = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
        key_byte <= 8'($urandom);
      end
      while (burst > 0 && req_q.size() != 0) begin
        cur = req_q.pop_front();
        @(negedge clk);
        in_valid <= 1'b1;
        key_byte <= cur.data;
        key_length <= cur.len;
        last_byte <= cur.last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_byte(cur.data, cur.len, cur.last);
        bytes_sent++;
        burst--;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (tracker.expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [HASH_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    seed_wdata <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.seed = v;
    seeds_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [HASH_W-1:0] seeds[6];
    seeds[0] = '0;
    seeds[1] = $urandom;
    seeds[2] = SEED_RESET;
    seeds[3] = 32'h8000_0000;
    seeds[4] = $urandom;
    seeds[5] = '1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed keys on the reset seed
    queue_key(1, '0, 'hFF, 1'b1);
    queue_key(1, LENGTH_BITS'(1), 'h00, 1'b1);
    queue_key(1, '1, 'hFF, 1'b1);
    queue_key(2, '0, 'hA5, 1'b1);
    queue_key(4, LENGTH_BITS'(4), 'hFF, 1'b1);
    queue_key(7, LENGTH_BITS'(7), -1, 1'b1);
    queue_key(3, LENGTH_BITS'(9), -1, 1'b1);
    send_all();
    settle();

    // seed change in the middle of a key
    write_seed('1);
    queue_key(2, LENGTH_BITS'(5), -1, 1'b0);
    send_all();
    settle();
    write_seed($urandom);
    queue_key(3, LENGTH_BITS'(5), -1, 1'b1);
    queue_key(1, LENGTH_BITS'(1), -1, 1'b1);
    send_all();
    settle();

    for (int p = 0; p < 6; p++) begin
      write_seed(seeds[p]);
      sender_gaps = (p % 2 == 0);
      if (p == 3) begin
        sender_gaps = 1'b0;
        long_hold_req = 1'b1;
      end
      queue_random_keys(200);
      send_all();
      settle();
    end

    $display("sent %0d key bytes, checked %0d hashes over %0d seed writes",
             bytes_sent, tracker.hashes_seen, seeds_written);
    $display("keys of 1 to 64 bytes, empty and zero-length keys, mid-key seed, long output hold");
    if (tracker.mismatches == 0 && tracker.expected_hashes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
